// ===== src/ktc_pkg.sv =====
package ktc_pkg;

    // slot and key geometry
    localparam int NUM_SLOTS      = 10;
    localparam int NUM_CYCLE_KEYS = 2;
    localparam int KEY_COUNT      = NUM_SLOTS + NUM_CYCLE_KEYS + 1;
    localparam int MAP_KEYS       = 13;
    localparam int MATCH_KEYS     = (KEY_COUNT < MAP_KEYS) ? KEY_COUNT : MAP_KEYS;
    localparam int MAP_W          = 8 * MAP_KEYS;
    localparam int SLOT_IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KEY_W          = $clog2(KEY_COUNT);

    // field widths
    localparam int TIME_W    = 32;
    localparam int THR_W     = 16;
    localparam int CODE_W    = 8;
    localparam int SLOT_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;
    localparam int MAP_LO_W  = 64;
    localparam int MAP_HI_W  = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_HOLD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP_HIGH = 3'd6;

    // key edge codes
    localparam logic [1:0] EDGE_DOWN = 2'd0;
    localparam logic [1:0] EDGE_HELD = 2'd1;
    localparam logic [1:0] EDGE_UP   = 2'd2;

    // slot flag bits
    localparam int FLAG_PRESSED = 0;
    localparam int FLAG_HOLD    = 1;
    localparam int FLAG_PENDING = 2;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_EQUIP_R    = 3'd1,
        ACT_EQUIP_L    = 3'd2,
        ACT_EQUIP_BOTH = 3'd3,
        ACT_CYCLE_TAP  = 3'd4,
        ACT_CYCLE_HOLD = 3'd5,
        ACT_TOGGLE     = 3'd6
    } action_t;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic              enabled;
        logic              read_only;
        logic [THR_W-1:0]  hold_ms;
        logic [THR_W-1:0]  double_tap_ms;
        logic [THR_W-1:0]  cycle_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] key_code;
        logic              from_keyboard;
        logic              typing_active;
        logic [1:0]        edge_req;
        logic [TIME_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic    consumed;
        action_t action;
        slot_t   slot;
        logic    cycle_backward;
        logic    last;
    } result_t;

    typedef struct packed {
        logic               hit;
        logic               is_slot;
        logic               is_cycle;
        logic [SLOT_IW-1:0] slot;
        logic               backward;
    } match_t;

endpackage

// ===== src/ktc_in_if.sv =====
interface ktc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [ktc_pkg::CODE_W-1:0] key_code;
    logic                       from_keyboard;
    logic                       typing_active;
    logic [1:0]                 edge_req;
    logic [ktc_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, func, key_code, from_keyboard, typing_active, edge_req,
                    now_ms, input ready);
    modport sink (input valid, func, key_code, from_keyboard, typing_active, edge_req,
                  now_ms, output ready);
endinterface

// ===== src/ktc_out_if.sv =====
interface ktc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       consumed;
    logic [2:0]                 action;
    logic [ktc_pkg::SLOT_W-1:0] slot;
    logic                       cycle_backward;
    logic                       last;

    modport source (output valid, consumed, action, slot, cycle_backward, last,
                    input ready);
    modport sink (input valid, consumed, action, slot, cycle_backward, last,
                  output ready);
endinterface

// ===== src/ktc_cfg_if.sv =====
interface ktc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ktc_pkg::CFG_IDX_W-1:0] index;
    logic [ktc_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/key_tap_hold_double_tap_classifier.sv =====
// Sequence: a key event gives its single result from the decode state, or for cycle keys
// and for slot keys outside read-only mode from the slot or cycle state after it; a frame
// tick scans one slot timer per cycle across all NUM_SLOTS slots, then sends one result
// per fired slot, one per cycle while the output is not stalled. Throughput: one item at a
// time; the input is ready again once the last result is registered.
// Reset: asynchronous, clears all press state and times, loads the default settings.
module key_tap_hold_double_tap_classifier (
    input  logic       clk,
    input  logic       rst_n,
    ktc_in_if.sink     in_ch,
    ktc_out_if.source  out_ch,
    ktc_cfg_if.sink    cfg_ch
);

    logic                              enabled_reg;
    logic                              read_only_reg;
    logic [ktc_pkg::THR_W-1:0]         hold_reg;
    logic [ktc_pkg::THR_W-1:0]         dtap_reg;
    logic [ktc_pkg::THR_W-1:0]         chold_reg;
    logic [ktc_pkg::MAP_LO_W-1:0]      map_low_reg;
    logic [ktc_pkg::MAP_HI_W-1:0]      map_high_reg;

    logic                              cfg_wr;
    logic                              map_write;
    ktc_pkg::cfg_t                     cfg;
    ktc_pkg::in_item_t                 in_item;
    ktc_pkg::result_t                  res;

    // configuration writes are always taken
    assign cfg_ch.ready = 1'b1;
    assign cfg_wr       = cfg_ch.valid;
    assign map_write    = cfg_wr && (cfg_ch.index == ktc_pkg::REG_KEY_MAP_LOW ||
                                     cfg_ch.index == ktc_pkg::REG_KEY_MAP_HIGH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b1;
            read_only_reg <= 1'b0;
            hold_reg      <= ktc_pkg::THR_W'(500);
            dtap_reg      <= ktc_pkg::THR_W'(300);
            chold_reg     <= ktc_pkg::THR_W'(500);
            map_low_reg   <= '0;
            map_high_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_ch.index)
                ktc_pkg::REG_ENABLED:      enabled_reg   <= cfg_ch.data[0];
                ktc_pkg::REG_READ_ONLY:    read_only_reg <= cfg_ch.data[0];
                ktc_pkg::REG_HOLD_MS:      hold_reg      <= cfg_ch.data[ktc_pkg::THR_W-1:0];
                ktc_pkg::REG_DOUBLE_TAP:   dtap_reg      <= cfg_ch.data[ktc_pkg::THR_W-1:0];
                ktc_pkg::REG_CYCLE_HOLD:   chold_reg     <= cfg_ch.data[ktc_pkg::THR_W-1:0];
                ktc_pkg::REG_KEY_MAP_LOW:  map_low_reg   <= cfg_ch.data[ktc_pkg::MAP_LO_W-1:0];
                ktc_pkg::REG_KEY_MAP_HIGH: map_high_reg  <= cfg_ch.data[ktc_pkg::MAP_HI_W-1:0];
                default:                   enabled_reg   <= enabled_reg;
            endcase
        end
    end

    // settings bundle for the sequencer
    always_comb
    begin
        cfg.enabled       = enabled_reg;
        cfg.read_only     = read_only_reg;
        cfg.hold_ms       = hold_reg;
        cfg.double_tap_ms = dtap_reg;
        cfg.cycle_hold_ms = chold_reg;
    end

    // input item fields
    always_comb
    begin
        in_item.func          = in_ch.func;
        in_item.key_code      = in_ch.key_code;
        in_item.from_keyboard = in_ch.from_keyboard;
        in_item.typing_active = in_ch.typing_active;
        in_item.edge_req      = in_ch.edge_req;
        in_item.now_ms        = in_ch.now_ms;
    end

    ktc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .key_map   ({map_high_reg, map_low_reg}),
        .map_write (map_write),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_item),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (res)
    );

    // result item fields
    assign out_ch.consumed       = res.consumed;
    assign out_ch.action         = res.action;
    assign out_ch.slot           = res.slot;
    assign out_ch.cycle_backward = res.cycle_backward;
    assign out_ch.last           = res.last;

endmodule

// ===== src/ktc_match.sv =====
module ktc_match (
    input  logic [ktc_pkg::MAP_W-1:0]  key_map,
    input  logic [ktc_pkg::CODE_W-1:0] key_code,
    output ktc_pkg::match_t            match
);

    logic                       hit;
    logic [ktc_pkg::KEY_W-1:0]  key;

    // priority search, lowest bound key wins
    always_comb
    begin
        hit = 1'b0;
        key = '0;
        for (int k = ktc_pkg::MATCH_KEYS - 1; k >= 0; k--)
        begin
            if (key_map[k*8 +: 8] != '0 && key_map[k*8 +: 8] == key_code)
            begin
                hit = 1'b1;
                key = ktc_pkg::KEY_W'(k);
            end
        end
    end

    // classify the matched key
    always_comb
    begin
        match.hit      = hit;
        match.is_slot  = key < ktc_pkg::KEY_W'(ktc_pkg::NUM_SLOTS);
        match.is_cycle = (key >= ktc_pkg::KEY_W'(ktc_pkg::NUM_SLOTS)) &&
                         (key < ktc_pkg::KEY_W'(ktc_pkg::NUM_SLOTS + ktc_pkg::NUM_CYCLE_KEYS));
        match.slot     = key[ktc_pkg::SLOT_IW-1:0];
        match.backward = key == ktc_pkg::KEY_W'(ktc_pkg::NUM_SLOTS);
    end

endmodule

// ===== src/ktc_elapsed.sv =====
module ktc_elapsed (
    input  logic [ktc_pkg::TIME_W-1:0] now_ms,
    input  logic [ktc_pkg::TIME_W-1:0] then_ms,
    input  logic [ktc_pkg::THR_W-1:0]  thr_ms,
    output logic                       ge,
    output logic                       gt
);

    logic [ktc_pkg::TIME_W-1:0] diff;
    logic [ktc_pkg::TIME_W-1:0] thr_ext;

    // wrapping elapsed time against a threshold
    assign diff    = now_ms - then_ms;
    assign thr_ext = ktc_pkg::TIME_W'(thr_ms);
    assign ge      = diff >= thr_ext;
    assign gt      = diff > thr_ext;

endmodule

// ===== src/ktc_core.sv =====
module ktc_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ktc_pkg::cfg_t             cfg,
    input  logic [ktc_pkg::MAP_W-1:0] key_map,
    input  logic                      map_write,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ktc_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output ktc_pkg::result_t          out_res
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SLOT   = 6'b000100,
        S_CYCLE  = 6'b001000,
        S_SCAN   = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    localparam int NS = ktc_pkg::NUM_SLOTS;
    localparam int NC = ktc_pkg::NUM_CYCLE_KEYS;
    localparam int TW = ktc_pkg::TIME_W;
    localparam int IW = ktc_pkg::SLOT_IW;

    state_t                   state_reg, state_next;
    ktc_pkg::in_item_t        item_reg, item_next;
    logic [TW-1:0]            frame_time_reg, frame_time_next;
    logic [TW-1:0]            press_time_reg [NS];
    logic [TW-1:0]            press_time_next [NS];
    logic [TW-1:0]            tap_time_reg [NS];
    logic [TW-1:0]            tap_time_next [NS];
    logic [2:0]               sflags_reg [NS];
    logic [2:0]               sflags_next [NS];
    logic [TW-1:0]            cyc_time_reg [NC];
    logic [TW-1:0]            cyc_time_next [NC];
    logic [1:0]               cflags_reg [NC];
    logic [1:0]               cflags_next [NC];
    logic                     pending_reg, pending_next;
    logic [IW-1:0]            idx_reg, idx_next;
    logic                     csel_reg, csel_next;
    logic [NS-1:0]            fire_reg, fire_next;
    ktc_pkg::result_t         res_reg, res_next;
    logic                     res_valid_reg, res_valid_next;

    ktc_pkg::match_t          match;
    logic [TW-1:0]            el_then;
    logic [ktc_pkg::THR_W-1:0] el_thr;
    logic                     el_ge;
    logic                     el_gt;
    logic                     out_free;
    logic                     ignore;
    logic [2:0]               sf;
    logic [1:0]               cf;
    ktc_pkg::action_t         act;
    logic [IW-1:0]            lo;
    logic [NS-1:0]            rest;

    ktc_match u_match (
        .key_map  (key_map),
        .key_code (item_reg.key_code),
        .match    (match)
    );

    // shared elapsed-time compare, operands picked by state and edge
    always_comb
    begin
        el_then = tap_time_reg[idx_reg];
        el_thr  = cfg.double_tap_ms;
        if (state_reg == S_SLOT && item_reg.edge_req == ktc_pkg::EDGE_HELD)
        begin
            el_then = press_time_reg[idx_reg];
            el_thr  = cfg.hold_ms;
        end
        else if (state_reg == S_CYCLE)
        begin
            el_then = cyc_time_reg[csel_reg];
            el_thr  = cfg.cycle_hold_ms;
        end
    end

    ktc_elapsed u_elapsed (
        .now_ms  (frame_time_reg),
        .then_ms (el_then),
        .thr_ms  (el_thr),
        .ge      (el_ge),
        .gt      (el_gt)
    );

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;
    assign out_free  = !res_valid_reg || out_ready;
    assign ignore    = !cfg.enabled || !item_reg.from_keyboard || item_reg.typing_active;

    // lowest fired slot for the emit pass
    always_comb
    begin
        lo = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (fire_reg[i])
            begin
                lo = IW'(i);
            end
        end
        rest = fire_reg & ~(NS'(1) << lo);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        frame_time_next = frame_time_reg;
        press_time_next = press_time_reg;
        tap_time_next   = tap_time_reg;
        sflags_next     = sflags_reg;
        cyc_time_next   = cyc_time_reg;
        cflags_next     = cflags_reg;
        pending_next    = pending_reg || map_write;
        idx_next        = idx_reg;
        csel_next       = csel_reg;
        fire_next       = fire_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && !out_ready;
        sf              = sflags_reg[idx_reg];
        cf              = cflags_reg[csel_reg];
        act             = ktc_pkg::ACT_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    if (in_item.func)
                    begin
                        // tick: take a pending clear, then scan slots
                        if (pending_reg)
                        begin
                            for (int i = 0; i < NS; i++)
                            begin
                                press_time_next[i] = '0;
                                tap_time_next[i]   = '0;
                                sflags_next[i]     = '0;
                            end
                            for (int c = 0; c < NC; c++)
                            begin
                                cyc_time_next[c] = '0;
                                cflags_next[c]   = '0;
                            end
                            pending_next = 1'b0;
                        end
                        frame_time_next = in_item.now_ms;
                        idx_next        = '0;
                        fire_next       = '0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DECODE;
                    end
                end
            end

            S_DECODE:
            begin
                if (out_free)
                begin
                    res_next.consumed       = 1'b0;
                    res_next.action         = ktc_pkg::ACT_NONE;
                    res_next.slot           = '0;
                    res_next.cycle_backward = 1'b0;
                    res_next.last           = 1'b1;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                    if (!ignore)
                    begin
                        if (pending_reg)
                        begin
                            for (int i = 0; i < NS; i++)
                            begin
                                press_time_next[i] = '0;
                                tap_time_next[i]   = '0;
                                sflags_next[i]     = '0;
                            end
                            for (int c = 0; c < NC; c++)
                            begin
                                cyc_time_next[c] = '0;
                                cflags_next[c]   = '0;
                            end
                            pending_next = 1'b0;
                        end
                        if (match.hit)
                        begin
                            res_next.consumed = 1'b1;
                            if (match.is_slot)
                            begin
                                if (!cfg.read_only)
                                begin
                                    res_valid_next = 1'b0;
                                    idx_next       = match.slot;
                                    state_next     = S_SLOT;
                                end
                            end
                            else if (match.is_cycle)
                            begin
                                res_valid_next = 1'b0;
                                csel_next      = !match.backward;
                                state_next     = S_CYCLE;
                            end
                            else if (item_reg.edge_req == ktc_pkg::EDGE_DOWN)
                            begin
                                res_next.action = ktc_pkg::ACT_TOGGLE;
                            end
                        end
                    end
                end
            end

            S_SLOT:
            begin
                if (out_free)
                begin
                    case (item_reg.edge_req)
                        ktc_pkg::EDGE_DOWN:
                        begin
                            press_time_next[idx_reg] = frame_time_reg;
                            sf[ktc_pkg::FLAG_PRESSED] = 1'b1;
                            sf[ktc_pkg::FLAG_HOLD]    = 1'b0;
                        end
                        ktc_pkg::EDGE_HELD:
                        begin
                            if (sf[ktc_pkg::FLAG_PRESSED] && !sf[ktc_pkg::FLAG_HOLD] && el_ge)
                            begin
                                sf[ktc_pkg::FLAG_HOLD]    = 1'b1;
                                sf[ktc_pkg::FLAG_PENDING] = 1'b0;
                                act = ktc_pkg::ACT_EQUIP_BOTH;
                            end
                        end
                        ktc_pkg::EDGE_UP:
                        begin
                            if (sf[ktc_pkg::FLAG_PRESSED] && !sf[ktc_pkg::FLAG_HOLD])
                            begin
                                if (sf[ktc_pkg::FLAG_PENDING] && !el_ge)
                                begin
                                    sf[ktc_pkg::FLAG_PENDING] = 1'b0;
                                    act = ktc_pkg::ACT_EQUIP_L;
                                end
                                else
                                begin
                                    tap_time_next[idx_reg] = frame_time_reg;
                                    sf[ktc_pkg::FLAG_PENDING] = 1'b1;
                                end
                            end
                            sf[ktc_pkg::FLAG_PRESSED] = 1'b0;
                        end
                        default:
                        begin
                            sf = sflags_reg[idx_reg];
                        end
                    endcase
                    sflags_next[idx_reg]    = sf;
                    res_next.consumed       = 1'b1;
                    res_next.action         = act;
                    res_next.slot           = (act != ktc_pkg::ACT_NONE) ?
                                              ktc_pkg::slot_t'(idx_reg) : '0;
                    res_next.cycle_backward = 1'b0;
                    res_next.last           = 1'b1;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            S_CYCLE:
            begin
                if (out_free)
                begin
                    case (item_reg.edge_req)
                        ktc_pkg::EDGE_DOWN:
                        begin
                            cyc_time_next[csel_reg] = frame_time_reg;
                            cf[ktc_pkg::FLAG_PRESSED] = 1'b1;
                            cf[ktc_pkg::FLAG_HOLD]    = 1'b0;
                        end
                        ktc_pkg::EDGE_HELD:
                        begin
                            if (cf[ktc_pkg::FLAG_PRESSED] && !cf[ktc_pkg::FLAG_HOLD] && el_ge)
                            begin
                                cf[ktc_pkg::FLAG_HOLD] = 1'b1;
                                act = ktc_pkg::ACT_CYCLE_HOLD;
                            end
                        end
                        ktc_pkg::EDGE_UP:
                        begin
                            if (cf[ktc_pkg::FLAG_PRESSED] && !cf[ktc_pkg::FLAG_HOLD])
                            begin
                                act = ktc_pkg::ACT_CYCLE_TAP;
                            end
                            cf[ktc_pkg::FLAG_PRESSED] = 1'b0;
                        end
                        default:
                        begin
                            cf = cflags_reg[csel_reg];
                        end
                    endcase
                    cflags_next[csel_reg]   = cf;
                    res_next.consumed       = 1'b1;
                    res_next.action         = act;
                    res_next.slot           = '0;
                    res_next.cycle_backward = (act != ktc_pkg::ACT_NONE) && !csel_reg;
                    res_next.last           = 1'b1;
                    res_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            S_SCAN:
            begin
                // one slot timer per cycle
                if (sflags_reg[idx_reg][ktc_pkg::FLAG_PENDING] && el_gt)
                begin
                    sflags_next[idx_reg][ktc_pkg::FLAG_PENDING] = 1'b0;
                    fire_next[idx_reg] = 1'b1;
                end
                if (idx_reg == IW'(NS - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (fire_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    res_next.consumed       = 1'b0;
                    res_next.action         = ktc_pkg::ACT_EQUIP_R;
                    res_next.slot           = ktc_pkg::slot_t'(lo);
                    res_next.cycle_backward = 1'b0;
                    res_next.last           = rest == '0;
                    res_valid_next          = 1'b1;
                    fire_next               = rest;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frame_time_reg <= '0;
            pending_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            csel_reg       <= 1'b0;
            fire_reg       <= '0;
            for (int i = 0; i < NS; i++)
            begin
                press_time_reg[i] <= '0;
                tap_time_reg[i]   <= '0;
                sflags_reg[i]     <= '0;
            end
            for (int c = 0; c < NC; c++)
            begin
                cyc_time_reg[c] <= '0;
                cflags_reg[c]   <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            frame_time_reg <= frame_time_next;
            pending_reg    <= pending_next;
            res_valid_reg  <= res_valid_next;
            idx_reg        <= idx_next;
            csel_reg       <= csel_next;
            fire_reg       <= fire_next;
            press_time_reg <= press_time_next;
            tap_time_reg   <= tap_time_next;
            sflags_reg     <= sflags_next;
            cyc_time_reg   <= cyc_time_next;
            cflags_reg     <= cflags_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

endmodule

// ===== bench/ktc_action_checker.sv =====
`timescale 1ns / 1ps

module ktc_action_checker (
    input  logic clk,
    input  logic rst_n,
    ktc_in_if    in_ch,
    ktc_out_if   out_ch,
    ktc_cfg_if   cfg_ch,
    output int   errors,
    output int   pending
);
    import ktc_pkg::*;

    // settings as last written
    logic                en_q;
    logic                ro_q;
    logic [THR_W-1:0]    hold_q;
    logic [THR_W-1:0]    dtap_q;
    logic [THR_W-1:0]    chold_q;
    logic [MAP_LO_W-1:0] map_lo_q;
    logic [MAP_HI_W-1:0] map_hi_q;

    // press tracking
    logic [TIME_W-1:0] frame_ms;
    logic [TIME_W-1:0] slot_down_ms [NUM_SLOTS];
    logic [TIME_W-1:0] slot_tap_ms [NUM_SLOTS];
    logic [2:0]        slot_st [NUM_SLOTS];
    logic [TIME_W-1:0] cyc_down_ms [NUM_CYCLE_KEYS];
    logic [1:0]        cyc_st [NUM_CYCLE_KEYS];
    logic              wipe_due;

    result_t due_results [$];

    function automatic result_t mk(input logic cons, input action_t act, input int slot_idx,
                                   input logic back, input logic fin);
        result_t r;
        r.consumed       = cons;
        r.action         = act;
        r.slot           = slot_t'(slot_idx);
        r.cycle_backward = back;
        r.last           = fin;
        return r;
    endfunction

    function automatic void clear_presses();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_down_ms[i] = '0;
            slot_tap_ms[i]  = '0;
            slot_st[i]      = '0;
        end
        for (int c = 0; c < NUM_CYCLE_KEYS; c++)
        begin
            cyc_down_ms[c] = '0;
            cyc_st[c]      = '0;
        end
    endfunction

    function automatic void load_defaults();
        en_q     = 1'b1;
        ro_q     = 1'b0;
        hold_q   = 16'd500;
        dtap_q   = 16'd300;
        chold_q  = 16'd500;
        map_lo_q = '0;
        map_hi_q = '0;
        frame_ms = '0;
        wipe_due = 1'b0;
        clear_presses();
        due_results.delete();
    endfunction

    function automatic logic [CODE_W-1:0] code_of(input int k);
        if (k < 8)
            return map_lo_q[8*k +: 8];
        if (k < MAP_KEYS)
            return map_hi_q[8*(k-8) +: 8];
        return '0;
    endfunction

    // a key map rewrite clears press state on the next tick or passing key event
    function automatic void take_wipe();
        if (wipe_due)
        begin
            clear_presses();
            wipe_due = 1'b0;
        end
    endfunction

    function automatic void write_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DAT_W-1:0] value);
        case (idx)
            REG_ENABLED:      en_q    = value[0];
            REG_READ_ONLY:    ro_q    = value[0];
            REG_HOLD_MS:      hold_q  = value[THR_W-1:0];
            REG_DOUBLE_TAP:   dtap_q  = value[THR_W-1:0];
            REG_CYCLE_HOLD:   chold_q = value[THR_W-1:0];
            REG_KEY_MAP_LOW:
            begin
                map_lo_q = value[MAP_LO_W-1:0];
                wipe_due = 1'b1;
            end
            REG_KEY_MAP_HIGH:
            begin
                map_hi_q = value[MAP_HI_W-1:0];
                wipe_due = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // tick: lone taps whose window ran out become equip right, in slot order
    function automatic void predict_tick(input logic [TIME_W-1:0] now);
        logic [NUM_SLOTS-1:0] fired;
        logic [TIME_W-1:0]    gap;
        int                   top_idx;
        take_wipe();
        frame_ms = now;
        fired    = '0;
        top_idx  = -1;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            gap = frame_ms - slot_tap_ms[i];
            if (slot_st[i][FLAG_PENDING] && gap > {16'd0, dtap_q})
            begin
                slot_st[i][FLAG_PENDING] = 1'b0;
                fired[i] = 1'b1;
                top_idx  = i;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            if (fired[i])
                due_results.push_back(mk(1'b0, ACT_EQUIP_R, i, 1'b0, i == top_idx));
    endfunction

    function automatic action_t slot_event(input int s, input logic [1:0] ev);
        logic [2:0]        f;
        action_t           act;
        logic [TIME_W-1:0] held_for;
        logic [TIME_W-1:0] since_tap;
        f         = slot_st[s];
        act       = ACT_NONE;
        held_for  = frame_ms - slot_down_ms[s];
        since_tap = frame_ms - slot_tap_ms[s];
        case (ev)
            EDGE_DOWN:
            begin
                slot_down_ms[s]  = frame_ms;
                f[FLAG_PRESSED] = 1'b1;
                f[FLAG_HOLD]    = 1'b0;
            end
            EDGE_HELD:
            begin
                if (f[FLAG_PRESSED] && !f[FLAG_HOLD] && held_for >= {16'd0, hold_q})
                begin
                    f[FLAG_HOLD]    = 1'b1;
                    f[FLAG_PENDING] = 1'b0;
                    act = ACT_EQUIP_BOTH;
                end
            end
            EDGE_UP:
            begin
                if (f[FLAG_PRESSED] && !f[FLAG_HOLD])
                begin
                    if (f[FLAG_PENDING] && since_tap < {16'd0, dtap_q})
                    begin
                        f[FLAG_PENDING] = 1'b0;
                        act = ACT_EQUIP_L;
                    end
                    else
                    begin
                        slot_tap_ms[s]  = frame_ms;
                        f[FLAG_PENDING] = 1'b1;
                    end
                end
                f[FLAG_PRESSED] = 1'b0;
            end
            default: ;
        endcase
        slot_st[s] = f;
        return act;
    endfunction

    function automatic action_t cycle_event(input int c, input logic [1:0] ev);
        logic [1:0]        f;
        action_t           act;
        logic [TIME_W-1:0] held_for;
        f        = cyc_st[c];
        act      = ACT_NONE;
        held_for = frame_ms - cyc_down_ms[c];
        case (ev)
            EDGE_DOWN:
            begin
                cyc_down_ms[c]  = frame_ms;
                f[FLAG_PRESSED] = 1'b1;
                f[FLAG_HOLD]    = 1'b0;
            end
            EDGE_HELD:
            begin
                if (f[FLAG_PRESSED] && !f[FLAG_HOLD] && held_for >= {16'd0, chold_q})
                begin
                    f[FLAG_HOLD] = 1'b1;
                    act = ACT_CYCLE_HOLD;
                end
            end
            EDGE_UP:
            begin
                if (f[FLAG_PRESSED] && !f[FLAG_HOLD])
                    act = ACT_CYCLE_TAP;
                f[FLAG_PRESSED] = 1'b0;
            end
            default: ;
        endcase
        cyc_st[c] = f;
        return act;
    endfunction

    // key event: exactly one result, first bound key with the code wins
    function automatic void predict_key(input in_item_t it);
        int      hit;
        int      c;
        action_t act;
        if (!en_q || !it.from_keyboard || it.typing_active)
        begin
            due_results.push_back(mk(1'b0, ACT_NONE, 0, 1'b0, 1'b1));
            return;
        end
        hit = -1;
        for (int k = 0; k < KEY_COUNT; k++)
            if (hit < 0 && code_of(k) != '0 && code_of(k) == it.key_code)
                hit = k;
        take_wipe();
        if (hit < 0)
            due_results.push_back(mk(1'b0, ACT_NONE, 0, 1'b0, 1'b1));
        else if (hit < NUM_SLOTS)
        begin
            act = ACT_NONE;
            if (!ro_q)
                act = slot_event(hit, it.edge_req);
            due_results.push_back(mk(1'b1, act, (act != ACT_NONE) ? hit : 0, 1'b0, 1'b1));
        end
        else if (hit < NUM_SLOTS + NUM_CYCLE_KEYS)
        begin
            c   = hit - NUM_SLOTS;
            act = cycle_event(c, it.edge_req);
            due_results.push_back(mk(1'b1, act, 0, (act != ACT_NONE) && (c == 0), 1'b1));
        end
        else
            due_results.push_back(mk(1'b1, (it.edge_req == EDGE_DOWN) ? ACT_TOGGLE : ACT_NONE,
                                     0, 1'b0, 1'b1));
    endfunction

    // watch all three channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        in_item_t item;
        result_t  want;
        if (!rst_n)
        begin
            load_defaults();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // compare outgoing item against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result: consumed=%0d action=%0d slot=%0d back=%0d last=%0d",
                                 out_ch.consumed, out_ch.action, out_ch.slot,
                                 out_ch.cycle_backward, out_ch.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_ch.consumed !== want.consumed || out_ch.action !== want.action ||
                        out_ch.slot !== want.slot || out_ch.cycle_backward !== want.cycle_backward ||
                        out_ch.last !== want.last)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("mismatch: want c=%0d a=%0d s=%0d b=%0d l=%0d, got c=%0d a=%0d s=%0d b=%0d l=%0d",
                                     want.consumed, want.action, want.slot, want.cycle_backward,
                                     want.last, out_ch.consumed, out_ch.action, out_ch.slot,
                                     out_ch.cycle_backward, out_ch.last);
                    end
                end
            end

            // register writes
            if (cfg_ch.valid && cfg_ch.ready)
                write_setting(cfg_ch.index, cfg_ch.data);

            // accepted input item
            if (in_ch.valid && in_ch.ready)
            begin
                item.func          = in_ch.func;
                item.key_code      = in_ch.key_code;
                item.from_keyboard = in_ch.from_keyboard;
                item.typing_active = in_ch.typing_active;
                item.edge_req      = in_ch.edge_req;
                item.now_ms        = in_ch.now_ms;
                if (item.func)
                    predict_tick(item.now_ms);
                else
                    predict_key(item);
            end

            pending <= due_results.size();
        end
    end

endmodule

// ===== bench/key_tap_hold_double_tap_classifier_tb.sv =====
`timescale 1ns / 1ps

module key_tap_hold_double_tap_classifier_tb;
    import ktc_pkg::*;

    localparam logic [1:0] EDGE_ODD        = 2'd3;
    localparam int         PHASES          = 8;
    localparam int         PHASE_GOAL      = 12;
    localparam int         SETTLE_CYCLES   = 24;
    localparam int         HOLD_OFF_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    int fail_count;
    int results_due;

    // stimulus control shared with the receiver
    bit quiet;
    bit hold_request;
    int hold_left;

    // settings as driven, used to aim the stimulus
    int                hold_cur;
    int                dtap_cur;
    int                chold_cur;
    logic [CODE_W-1:0] map_codes [KEY_COUNT];
    logic [TIME_W-1:0] clock_ms;
    int                counted;

    ktc_in_if  in_ch ();
    ktc_out_if out_ch ();
    ktc_cfg_if cfg_ch ();

    key_tap_hold_double_tap_classifier uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    ktc_action_checker action_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch),
        .errors  (fail_count),
        .pending (results_due)
    );

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = quiet || ($urandom_range(99) >= 25);
        end
    end

    function automatic logic [TIME_W-1:0] step_near(input int thr);
        case ($urandom_range(7))
            0:       return '0;
            1:       return thr;
            2:       return thr + 1;
            3:       return (thr > 0) ? thr - 1 : 0;
            default: return $urandom_range(thr + thr / 2 + 2);
        endcase
    endfunction

    // random upper bits above the field width
    function automatic logic [CFG_DAT_W-1:0] pad(input logic [CFG_DAT_W-1:0] v, input int w);
        logic [CFG_DAT_W-1:0] r;
        logic [CFG_DAT_W-1:0] mask;
        r    = {$urandom, $urandom};
        mask = (64'd1 << w) - 64'd1;
        return (r & ~mask) | (v & mask);
    endfunction

    function automatic in_item_t noise_item();
        in_item_t it;
        it.func          = $urandom_range(1);
        it.key_code      = $urandom_range(255);
        it.from_keyboard = $urandom_range(1);
        it.typing_active = $urandom_range(1);
        it.edge_req      = $urandom_range(3);
        it.now_ms        = $urandom;
        return it;
    endfunction

    function automatic int pick_key();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return $urandom_range(NUM_SLOTS - 1);
        if (r < 9)
            return NUM_SLOTS + $urandom_range(NUM_CYCLE_KEYS - 1);
        return KEY_COUNT - 1;
    endfunction

    task automatic send_item(input in_item_t it);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 25)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.func          = it.func;
        in_ch.key_code      = it.key_code;
        in_ch.from_keyboard = it.from_keyboard;
        in_ch.typing_active = it.typing_active;
        in_ch.edge_req      = it.edge_req;
        in_ch.now_ms        = it.now_ms;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        counted++;
    endtask

    task automatic tick(input logic [TIME_W-1:0] step);
        in_item_t it;
        clock_ms  = clock_ms + step;
        it        = noise_item();
        it.func   = 1'b1;
        it.now_ms = clock_ms;
        send_item(it);
    endtask

    task automatic key_event(input logic [CODE_W-1:0] code, input logic [1:0] ev,
                             input logic kbd, input logic typing);
        in_item_t it;
        it               = noise_item();
        it.func          = 1'b0;
        it.key_code      = code;
        it.from_keyboard = kbd;
        it.typing_active = typing;
        it.edge_req      = ev;
        send_item(it);
    endtask

    task automatic press(input int k, input logic [1:0] ev);
        key_event(map_codes[k], ev, 1'b1, 1'b0);
    endtask

    // down, some ticks and held reports, up, maybe a second tap
    task automatic gesture(input int k);
        int thr;
        thr = (k < NUM_SLOTS) ? hold_cur : chold_cur;
        press(k, EDGE_DOWN);
        repeat ($urandom_range(2))
        begin
            tick(step_near(thr));
            if ($urandom_range(1))
                press(k, EDGE_HELD);
        end
        if ($urandom_range(2) != 0)
            press(k, EDGE_HELD);
        press(k, EDGE_UP);
        if (k < NUM_SLOTS && $urandom_range(1))
        begin
            if ($urandom_range(1))
                tick(step_near(dtap_cur));
            press(k, EDGE_DOWN);
            press(k, EDGE_UP);
        end
        if ($urandom_range(1))
            tick(step_near(dtap_cur));
    endtask

    // taps on many slots, then a tick past the window
    task automatic tap_burst(input bit every);
        for (int s = 0; s < NUM_SLOTS; s++)
            if (every || $urandom_range(3) != 0)
            begin
                press(s, EDGE_DOWN);
                press(s, EDGE_UP);
            end
        tick(dtap_cur + 1 + $urandom_range(50));
    endtask

    // wait until every predicted result is out and the block has gone quiet
    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic apply_settings(input logic en, input logic ro, input int h, input int d,
                                  input int c);
        write_reg(REG_ENABLED, pad(64'(en), 1));
        write_reg(REG_READ_ONLY, pad(64'(ro), 1));
        write_reg(REG_HOLD_MS, pad(64'(h), THR_W));
        write_reg(REG_DOUBLE_TAP, pad(64'(d), THR_W));
        write_reg(REG_CYCLE_HOLD, pad(64'(c), THR_W));
        hold_cur  = h;
        dtap_cur  = d;
        chold_cur = c;
    endtask

    // fresh map: some unbound keys and some repeated codes
    task automatic load_map(input bit fresh);
        logic [CFG_DAT_W-1:0] lo;
        logic [CFG_DAT_W-1:0] hi;
        int                   r;
        if (fresh)
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                r = $urandom_range(9);
                if (r == 0)
                    map_codes[k] = '0;
                else if (r == 1 && k > 0)
                    map_codes[k] = map_codes[$urandom_range(k - 1)];
                else
                    map_codes[k] = $urandom_range(255, 1);
            end
        lo = '0;
        hi = '0;
        for (int k = 0; k < 8; k++)
            lo[8*k +: 8] = map_codes[k];
        for (int k = 8; k < KEY_COUNT; k++)
            hi[8*(k-8) +: 8] = map_codes[k];
        write_reg(REG_KEY_MAP_LOW, lo);
        write_reg(REG_KEY_MAP_HIGH, pad(hi, MAP_HI_W));
    endtask

    initial
    begin
        int phase;
        int op;
        int start;
        int iter;
        int r;

        in_ch.valid         = 1'b0;
        in_ch.func          = 1'b0;
        in_ch.key_code      = '0;
        in_ch.from_keyboard = 1'b0;
        in_ch.typing_active = 1'b0;
        in_ch.edge_req      = EDGE_DOWN;
        in_ch.now_ms        = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_ENABLED;
        cfg_ch.data         = '0;
        quiet               = 1'b0;
        hold_request        = 1'b0;
        counted             = 0;
        clock_ms            = '0;
        hold_cur            = 500;
        dtap_cur            = 300;
        chold_cur           = 500;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fixed distinct map, default thresholds
        for (int k = 0; k < NUM_SLOTS; k++)
            map_codes[k] = 8'(8'h11 + k);
        map_codes[NUM_SLOTS]     = 8'h21;
        map_codes[NUM_SLOTS + 1] = 8'h22;
        map_codes[KEY_COUNT - 1] = 8'h23;
        load_map(1'b0);

        // lone tap on slot 0, double tap on slot 1
        tick(1000);
        press(0, EDGE_DOWN);
        tick(100);
        press(0, EDGE_UP);
        press(1, EDGE_DOWN);
        press(1, EDGE_UP);
        press(1, EDGE_DOWN);
        press(1, EDGE_UP);
        // window edge: exactly at the window nothing fires, one past it fires
        tick(300);
        tick(1);
        // hold on slot 2 at exactly the threshold
        press(2, EDGE_DOWN);
        tick(500);
        press(2, EDGE_HELD);
        press(2, EDGE_UP);
        // cycle tap on previous, cycle hold on next
        press(NUM_SLOTS, EDGE_DOWN);
        press(NUM_SLOTS, EDGE_UP);
        press(NUM_SLOTS + 1, EDGE_DOWN);
        tick(500);
        press(NUM_SLOTS + 1, EDGE_HELD);
        // toggle fires on down only
        press(KEY_COUNT - 1, EDGE_DOWN);
        press(KEY_COUNT - 1, EDGE_UP);
        // held and released without a down, unknown edge, unbound and ignored events
        press(3, EDGE_HELD);
        press(3, EDGE_UP);
        press(4, EDGE_ODD);
        key_event(8'hFF, EDGE_DOWN, 1'b1, 1'b0);
        key_event(map_codes[0], EDGE_DOWN, 1'b0, 1'b0);
        key_event(map_codes[0], EDGE_DOWN, 1'b1, 1'b1);
        drain();

        // random phases, each with its own settings; all but the first load a fresh key map
        for (phase = 0; phase < PHASES; phase++)
        begin
            quiet = (phase == 0) || (phase == 5);
            r = $urandom_range(600);
            case (phase)
                0: apply_settings(1'b1, 1'b0, r, $urandom_range(600), $urandom_range(600));
                1: apply_settings(1'b1, 1'b0, 0, 0, 0);
                2:
                begin
                    apply_settings(1'b1, 1'b0, 65535, 65535, 65535);
                    clock_ms = 32'hFFFF_8000 + $urandom_range(4095);
                end
                3: apply_settings(1'b1, 1'b1, r, r, r);
                4: apply_settings(1'b0, 1'b0, r, r, r);
                7: apply_settings(1'b1, 1'b0, $urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535));
                default: apply_settings(1'b1, 1'b0, r, $urandom_range(600), $urandom_range(600));
            endcase
            load_map(phase != 0);
            if (phase == 5)
                hold_request = 1'b1;
            if (phase == 0)
                tap_burst(1'b1);

            start = counted;
            iter  = 0;
            while (counted - start < PHASE_GOAL && iter < 60)
            begin
                iter++;
                op = $urandom_range(19);
                if (op < 12)
                    gesture(pick_key());
                else if (op < 14)
                    tick(step_near(dtap_cur));
                else if (op < 16)
                    key_event($urandom_range(255), $urandom_range(3), $urandom_range(3) != 0,
                              $urandom_range(3) == 0);
                else if (op < 18)
                    tap_burst(1'b0);
                else if (op == 18)
                begin
                    clock_ms = $urandom;
                    tick(0);
                end
                else
                    tick(step_near(hold_cur));
            end
            drain();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
